>>> hdl/gab_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gab_pkg;

	localparam int MAX_GLYPH = 256;
	localparam logic [12:0] SCREEN_LIMIT = 13'd4096;
	localparam logic [7:0] ALPHA_SOLID = 8'hFF;
	localparam logic [2:0] ALPHA_FLOOR = 3'h7;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 13;

	localparam logic [CFG_IDX_W-1:0] CFG_COLOR_RED     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COLOR_GREEN   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COLOR_BLUE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DEEP_COLOR    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 3'd7;

	typedef struct packed {
		logic [7:0] color_red;
		logic [7:0] color_green;
		logic [7:0] color_blue;
		logic deep_color;
		logic signed [12:0] origin_x;
		logic signed [12:0] origin_y;
		logic [12:0] screen_width;
		logic [12:0] screen_height;
	} gab_cfg_t;

	typedef struct packed {
		logic wr;
		logic solid;
		logic [7:0] alpha;
		logic [7:0] dst_r;
		logic [7:0] dst_g;
		logic [7:0] dst_b;
		logic [11:0] screen_x;
		logic [11:0] screen_y;
	} gab_s1_t;

	typedef struct packed {
		logic wr;
		logic solid;
		logic [15:0] src_r;
		logic [15:0] src_g;
		logic [15:0] src_b;
		logic [15:0] dst_r;
		logic [15:0] dst_g;
		logic [15:0] dst_b;
		logic [11:0] screen_x;
		logic [11:0] screen_y;
	} gab_s2_t;

	typedef struct packed {
		logic write_pixel;
		logic [23:0] new_pixel;
		logic [11:0] screen_x;
		logic [11:0] screen_y;
	} gab_out_t;

	function automatic logic [23:0] pack_pixel(input logic deep, input logic [7:0] r,
		input logic [7:0] g, input logic [7:0] b);
		if (deep) begin
			return {r, g, b};
		end
		return {9'd0, r[7:3], g[7:3], b[7:3]};
	endfunction

endpackage

`default_nettype wire

>>> hdl/gab_front.sv
`timescale 1ns / 1ps
`default_nettype none

module gab_front (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire gab_pkg::gab_cfg_t cfg,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire logic [7:0] coverage,
	input  wire logic [23:0] dest_pixel,
	input  wire logic [7:0] glyph_col,
	input  wire logic [7:0] glyph_row,
	output logic valid_s1,
	input  wire logic out_ready,
	output gab_pkg::gab_s1_t data_s1
);
	import gab_pkg::*;

	logic [7:0] alpha;
	logic signed [13:0] sx;
	logic signed [13:0] sy;
	logic [12:0] wlim;
	logic [12:0] hlim;
	logic in_glyph;
	logic on_screen;
	gab_s1_t next;

	always_comb begin
		alpha = coverage | {5'd0, ALPHA_FLOOR};
		sx = $signed({cfg.origin_x[12], cfg.origin_x}) + $signed({6'd0, glyph_col});
		sy = $signed({cfg.origin_y[12], cfg.origin_y}) + $signed({6'd0, glyph_row});
		wlim = (cfg.screen_width > SCREEN_LIMIT) ? SCREEN_LIMIT : cfg.screen_width;
		hlim = (cfg.screen_height > SCREEN_LIMIT) ? SCREEN_LIMIT : cfg.screen_height;
		in_glyph = (32'(glyph_col) < MAX_GLYPH) && (32'(glyph_row) < MAX_GLYPH);
		on_screen = !sx[13] && !sy[13] && (sx[12:0] < wlim) && (sy[12:0] < hlim);
		next.wr = in_glyph && on_screen && (alpha != {5'd0, ALPHA_FLOOR});
		next.solid = (alpha == ALPHA_SOLID);
		next.alpha = alpha;
		if (cfg.deep_color) begin
			next.dst_r = dest_pixel[23:16];
			next.dst_g = dest_pixel[15:8];
			next.dst_b = dest_pixel[7:0];
		end else begin
			next.dst_r = {dest_pixel[14:10], 3'd0};
			next.dst_g = {dest_pixel[9:5], 3'd0};
			next.dst_b = {dest_pixel[4:0], 3'd0};
		end
		next.screen_x = sx[11:0];
		next.screen_y = sy[11:0];
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= next;
		end
	end

endmodule

`default_nettype wire

>>> hdl/gab_mult.sv
`timescale 1ns / 1ps
`default_nettype none

module gab_mult (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire gab_pkg::gab_cfg_t cfg,
	input  wire logic valid_s1,
	output logic in_ready,
	input  wire gab_pkg::gab_s1_t data_s1,
	output logic valid_s2,
	input  wire logic out_ready,
	output gab_pkg::gab_s2_t data_s2
);
	import gab_pkg::*;

	logic [7:0] inv_alpha;
	gab_s2_t next;

	always_comb begin
		inv_alpha = ~data_s1.alpha;
		next.wr = data_s1.wr;
		next.solid = data_s1.solid;
		next.src_r = {8'd0, cfg.color_red} * {8'd0, data_s1.alpha};
		next.src_g = {8'd0, cfg.color_green} * {8'd0, data_s1.alpha};
		next.src_b = {8'd0, cfg.color_blue} * {8'd0, data_s1.alpha};
		next.dst_r = {8'd0, data_s1.dst_r} * {8'd0, inv_alpha};
		next.dst_g = {8'd0, data_s1.dst_g} * {8'd0, inv_alpha};
		next.dst_b = {8'd0, data_s1.dst_b} * {8'd0, inv_alpha};
		next.screen_x = data_s1.screen_x;
		next.screen_y = data_s1.screen_y;
	end

	assign in_ready = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && valid_s1) begin
			data_s2 <= next;
		end
	end

endmodule

`default_nettype wire

>>> hdl/gab_pack.sv
`timescale 1ns / 1ps
`default_nettype none

module gab_pack (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire gab_pkg::gab_cfg_t cfg,
	input  wire logic valid_s2,
	output logic in_ready,
	input  wire gab_pkg::gab_s2_t data_s2,
	output logic valid_s3,
	input  wire logic out_ready,
	output gab_pkg::gab_out_t data_s3
);
	import gab_pkg::*;

	logic [15:0] sum_r;
	logic [15:0] sum_g;
	logic [15:0] sum_b;
	logic [23:0] pix;
	gab_out_t next;

	always_comb begin
		sum_r = data_s2.src_r + data_s2.dst_r;
		sum_g = data_s2.src_g + data_s2.dst_g;
		sum_b = data_s2.src_b + data_s2.dst_b;
		if (data_s2.solid) begin
			pix = pack_pixel(cfg.deep_color, cfg.color_red, cfg.color_green, cfg.color_blue);
		end else begin
			pix = pack_pixel(cfg.deep_color, sum_r[15:8], sum_g[15:8], sum_b[15:8]);
		end
		next.write_pixel = data_s2.wr;
		next.new_pixel = data_s2.wr ? pix : 24'd0;
		next.screen_x = data_s2.wr ? data_s2.screen_x : 12'd0;
		next.screen_y = data_s2.wr ? data_s2.screen_y : 12'd0;
	end

	assign in_ready = !valid_s3 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && valid_s2) begin
			data_s3 <= next;
		end
	end

endmodule

`default_nettype wire

>>> hdl/glyph_alpha_blend_pixel.sv
`timescale 1ns / 1ps
`default_nettype none

// Blends one glyph coverage pixel over a framebuffer pixel per item. The block
// is a three-stage pipeline (unpack and clip, channel multiplies, sum and
// repack), so each result is registered by those stages in turn before it
// reaches the output, and one item is accepted every clock while the output
// side keeps m_axis_tready high.
// Each stage holds its item when the next one is full and cannot drain, so
// backpressure stalls the pipeline without loss. Write the configuration registers only while no
// item is in flight; cfg_ready is always high.
module glyph_alpha_blend_pixel (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_valid,
	output logic cfg_ready,
	input  wire logic [gab_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [gab_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic s_axis_tvalid,
	output logic s_axis_tready,
	// coverage[7:0], dest_pixel[31:8], glyph_col[39:32], glyph_row[47:40]
	input  wire logic [47:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  wire logic m_axis_tready,
	// new_pixel[23:0], screen_x[35:24], screen_y[47:36]
	output logic [47:0] m_axis_tdata,
	// write_pixel[0]
	output logic m_axis_tuser
);
	import gab_pkg::*;

	gab_cfg_t cfg_q;
	logic valid_s1;
	logic valid_s2;
	logic valid_s3;
	logic ready_s2;
	logic ready_s3;
	gab_s1_t data_s1;
	gab_s2_t data_s2;
	gab_out_t data_s3;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.color_red <= 8'd255;
			cfg_q.color_green <= 8'd255;
			cfg_q.color_blue <= 8'd255;
			cfg_q.deep_color <= 1'b0;
			cfg_q.origin_x <= 13'sd0;
			cfg_q.origin_y <= 13'sd0;
			cfg_q.screen_width <= 13'd640;
			cfg_q.screen_height <= 13'd480;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_COLOR_RED: cfg_q.color_red <= cfg_data[7:0];
				CFG_COLOR_GREEN: cfg_q.color_green <= cfg_data[7:0];
				CFG_COLOR_BLUE: cfg_q.color_blue <= cfg_data[7:0];
				CFG_DEEP_COLOR: cfg_q.deep_color <= cfg_data[0];
				CFG_ORIGIN_X: cfg_q.origin_x <= $signed(cfg_data);
				CFG_ORIGIN_Y: cfg_q.origin_y <= $signed(cfg_data);
				CFG_SCREEN_WIDTH: cfg_q.screen_width <= cfg_data;
				CFG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	gab_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.coverage(s_axis_tdata[7:0]),
		.dest_pixel(s_axis_tdata[31:8]),
		.glyph_col(s_axis_tdata[39:32]),
		.glyph_row(s_axis_tdata[47:40]),
		.valid_s1(valid_s1),
		.out_ready(ready_s2),
		.data_s1(data_s1)
	);

	gab_mult u_mult (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.valid_s1(valid_s1),
		.in_ready(ready_s2),
		.data_s1(data_s1),
		.valid_s2(valid_s2),
		.out_ready(ready_s3),
		.data_s2(data_s2)
	);

	gab_pack u_pack (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.valid_s2(valid_s2),
		.in_ready(ready_s3),
		.data_s2(data_s2),
		.valid_s3(valid_s3),
		.out_ready(m_axis_tready),
		.data_s3(data_s3)
	);

	assign m_axis_tvalid = valid_s3;
	assign m_axis_tuser = data_s3.write_pixel;
	assign m_axis_tdata = {data_s3.screen_y, data_s3.screen_x, data_s3.new_pixel};

	a_skip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 48'd0)
		else $error("skipped pixel carries nonzero data");

	a_enter_s1: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> valid_s1)
		else $error("accepted item missing from first stage");

	a_hold_s2: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !ready_s3 |=> valid_s2)
		else $error("second stage dropped a stalled item");

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !ready_s2 |=> valid_s1 && $stable(data_s1))
		else $error("first stage changed while stalled");

endmodule

`default_nettype wire
